// ----- rtl/core/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Holds entry and control words, operation codes and controller states.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int LKV_DATA_W      = 32;
  localparam int LKV_CAP_W       = 5;
  localparam int LKV_MAX_ENTRIES = 16;
  localparam logic [LKV_CAP_W-1:0] LKV_CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkv_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_UPD  = 2'd2
  } lkv_state_t;

  // One cache entry as it moves down the recency chain
  typedef struct packed {
    logic                         valid;
    logic signed [LKV_DATA_W-1:0] key;
    logic signed [LKV_DATA_W-1:0] value;
  } lkv_entry_t;

  // Controls broadcast from the controller to every cell
  typedef struct packed {
    logic                         cmp_en;
    logic                         upd_en;
    logic                         hit;
    logic                         ins;
    logic                         evict;
    logic signed [LKV_DATA_W-1:0] key;
  } lkv_ctrl_t;

endpackage

// ----- rtl/core/lkv_cell.sv -----
// ----------------------------------------------------------------------------
// lkv_cell: one slot of the recency-ordered entry chain
// Compares its key with the request, and on update loads the entry of its
// more recent neighbor, so the chain stays sorted most recent first.
// ----------------------------------------------------------------------------
module lkv_cell
  import lkv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lkv_ctrl_t  ctrl,
  input  lkv_entry_t prev_ent,
  input  logic       next_valid,
  input  logic       sh_in,
  output logic       sh_out,
  output lkv_entry_t ent,
  output logic       match,
  output logic       last
);

  logic                         valid_r, valid_nxt;
  logic signed [LKV_DATA_W-1:0] key_r, key_nxt;
  logic signed [LKV_DATA_W-1:0] value_r, value_nxt;
  logic                         match_r, match_nxt;
  logic                         load;

  // a hit here or in any older cell moves this cell down by one
  assign sh_out = match_r | sh_in;

  // take the neighbor's word on a hit shift or on an insert
  assign load = ctrl.upd_en &
                ((ctrl.hit & sh_out) | (ctrl.ins & (~ctrl.evict | valid_r)));

  always_comb begin
    match_nxt = ctrl.cmp_en ? (valid_r && (key_r == ctrl.key)) : match_r;
    valid_nxt = load ? prev_ent.valid : valid_r;
    key_nxt   = load ? prev_ent.key   : key_r;
    value_nxt = load ? prev_ent.value : value_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign ent   = '{valid: valid_r, key: key_r, value: value_r};
  assign match = match_r;
  assign last  = valid_r & ~next_valid;

endmodule

// ----- rtl/core/lkv_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkv_ctrl: request register, sequencer and fill count of the cache
// Latches a request, runs the lookup and update phases and keeps the
// number of entries in use.
// ----------------------------------------------------------------------------
module lkv_ctrl
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = LKV_MAX_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_operation,
  input  logic signed [LKV_DATA_W-1:0]           in_key,
  input  logic signed [LKV_DATA_W-1:0]           in_value,
  input  logic [LKV_CAP_W-1:0]                   capacity,
  input  logic                                   any_hit,
  output lkv_ctrl_t                              ctrl,
  output lkv_op_t                                op,
  output logic signed [LKV_DATA_W-1:0]           req_value
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EW    = (CNT_W > LKV_CAP_W) ? CNT_W : LKV_CAP_W;

  lkv_state_t                   state_r, state_nxt;
  lkv_op_t                      op_r, op_nxt;
  logic signed [LKV_DATA_W-1:0] key_r, key_nxt;
  logic signed [LKV_DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [EW-1:0]                cap_eff;
  logic [EW-1:0]                cap_ext;
  logic                         accept;
  logic                         full;
  logic                         upd, ins;

  assign accept = start & ~busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = accept ? ST_LOOK : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = 1'b0;
    upd  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_LOOK: busy = 1'b1;
      ST_UPD:  upd  = 1'b1;
      default: ;
    endcase
  end

  // clamp capacity into 1 .. MAX_ENTRIES
  always_comb begin
    cap_ext = EW'(capacity);
    if (cap_ext == '0)                   cap_eff = EW'(1);
    else if (cap_ext > EW'(MAX_ENTRIES)) cap_eff = EW'(MAX_ENTRIES);
    else                                 cap_eff = cap_ext;
  end

  assign full = EW'(count_r) >= cap_eff;
  assign ins  = (op_r == OP_PUT) & ~any_hit;

  always_comb begin
    ctrl.cmp_en = (state_r == ST_LOOK);
    ctrl.upd_en = upd;
    ctrl.hit    = any_hit;
    ctrl.ins    = ins;
    ctrl.evict  = ins & full;
    ctrl.key    = key_r;
  end

  // capture request and track fill count
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    if (accept) begin
      op_nxt  = lkv_op_t'(in_operation);
      key_nxt = in_key;
      val_nxt = in_value;
    end
    if (upd && ins && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign op        = op_r;
  assign req_value = val_r;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Entries sit in a chain of cells ordered most recent first.
// ----------------------------------------------------------------------------
// Usage:
//   Command: drive in_operation (0 get, 1 put), in_key, in_value and raise
//   start; the command is taken at a rising edge with start high and busy low.
//   Result: one word per command, shown for one cycle with out_valid high:
//   out_hit, out_read_value (get hit only), out_evicted, out_evicted_key.
//   Steps: the compare state compares the key with every cell at once and
//   registers the match bits; the update state then shifts the chain (the
//   hit or new entry goes to the head) and registers the result word. A new
//   command can be accepted during the update state.
//   busy is high only in the compare cycle.
//   Capacity: cfg_wr_en/cfg_wr_data write the capacity register (1..MAX_ENTRIES kept,
//   0 acts as 1, above MAX_ENTRIES acts as MAX_ENTRIES); write while idle.
//   Reset: synchronous, clears all valid bits, the fill count and sets
//   capacity to 16; no clearing pass is needed.
//   The receiver cannot hold results off; every result word is shown once.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = LKV_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic signed [LKV_DATA_W-1:0] in_key,
  input  logic signed [LKV_DATA_W-1:0] in_value,
  input  logic                         cfg_wr_en,
  input  logic [LKV_CAP_W-1:0]         cfg_wr_data,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [LKV_DATA_W-1:0] out_read_value,
  output logic                         out_evicted,
  output logic signed [LKV_DATA_W-1:0] out_evicted_key
);

  lkv_ctrl_t                    ctrl;
  lkv_op_t                      op;
  logic signed [LKV_DATA_W-1:0] req_value;
  logic [LKV_CAP_W-1:0]         cap_r, cap_nxt;

  lkv_entry_t                   ent   [MAX_ENTRIES];
  lkv_entry_t                   prev  [MAX_ENTRIES];
  logic                         nvld  [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]         sh;
  logic [MAX_ENTRIES-1:0]       match;
  logic [MAX_ENTRIES-1:0]       last;

  logic                         any_hit;
  logic signed [LKV_DATA_W-1:0] hit_value;
  logic signed [LKV_DATA_W-1:0] tail_key;
  lkv_entry_t                   head;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic signed [LKV_DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic                         out_ev_r, out_ev_nxt;
  logic signed [LKV_DATA_W-1:0] out_evk_r, out_evk_nxt;

  // capacity register
  assign cap_nxt = cfg_wr_en ? cfg_wr_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LKV_CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lkv_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_value     (in_value),
    .capacity     (cap_r),
    .any_hit      (any_hit),
    .ctrl         (ctrl),
    .op           (op),
    .req_value    (req_value)
  );

  // gather hit value and tail key over the cells
  always_comb begin
    any_hit   = |match;
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_value = hit_value | (ent[i].value & {LKV_DATA_W{match[i]}});
      tail_key  = tail_key  | (ent[i].key   & {LKV_DATA_W{last[i]}});
    end
  end

  // head word: the touched or new entry enters at the most recent end
  always_comb begin
    head.valid = 1'b1;
    head.key   = ctrl.key;
    head.value = (op == OP_PUT) ? req_value : hit_value;
  end

  assign sh[MAX_ENTRIES] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev[g] = head;
    end else begin : g_body
      assign prev[g] = ent[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign nvld[g] = 1'b0;
    end else begin : g_mid
      assign nvld[g] = ent[g+1].valid;
    end

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_ent   (prev[g]),
      .next_valid (nvld[g]),
      .sh_in      (sh[g+1]),
      .sh_out     (sh[g]),
      .ent        (ent[g]),
      .match      (match[g]),
      .last       (last[g])
    );
  end

  // result word, registered at the end of the update cycle
  always_comb begin
    out_valid_nxt = ctrl.upd_en;
    out_hit_nxt   = any_hit;
    out_rd_nxt    = (op == OP_GET && any_hit) ? hit_value : '0;
    out_ev_nxt    = ctrl.evict;
    out_evk_nxt   = ctrl.evict ? tail_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ev_r  <= out_ev_nxt;
    out_evk_r <= out_evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

// ----- rtl/core/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks for the LRU key-value cache
// Watches command and result timing and result consistency.
// ----------------------------------------------------------------------------
module lkv_checker
  import lkv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_operation,
  input  logic                         out_valid,
  input  logic                         out_hit,
  input  logic                         out_evicted,
  input  logic signed [LKV_DATA_W-1:0] out_evicted_key
);

  logic accept;
  assign accept = start & ~busy;

  // every accepted command yields a result word
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted command produced no result word");

  // no result word without a command behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result word without accepted command");

  // the compare cycle blocks the next command
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // a get never evicts
  a_get_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_operation, 3) == OP_GET)) |-> !out_evicted)
    else $error("get command reported an eviction");

  // eviction only on a miss; key is zero when nothing is evicted
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_evicted && out_hit) &&
                   (out_evicted || out_evicted_key == '0)))
    else $error("inconsistent eviction fields");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);
